[rtl/core/jetc_pkg.sv]
// Shared types and constants for the Julia escape-time counter.
// No dependencies; compiled first.
package jetc_pkg;

  localparam int DATA_W    = 32;  // Q3.28 coordinate and constant width
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ITER_W    = 16;  // iteration limit width
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] C_RESET      = '0;
  localparam logic [ITER_W-1:0] MAX_IT_RESET = 16'd1000;
  localparam logic [DATA_W-1:0] ESC_RESET    = 32'd1073741824;  // 4.0, radius 2.0

  localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C_REAL    = 2'd0,
    CFG_C_IMAG    = 2'd1,
    CFG_MAX_ITER  = 2'd2,
    CFG_ESC_LIMIT = 2'd3
  } cfg_idx_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture new starting point, clear count
    logic mult;     // register the three products
    logic step;     // commit z = z*z + c, count++
    logic publish;  // copy count to result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic keep_going;  // below limit, not saturated, inside radius
  } stat_t;

endpackage

[rtl/core/jetc_in_if.sv]
// Input stream: one starting point per transfer.
// Depends on jetc_pkg.
interface jetc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [jetc_pkg::DATA_W-1:0]  z_real;
  logic signed [jetc_pkg::DATA_W-1:0]  z_imag;

  modport source (output valid, z_real, z_imag, input ready);
  modport sink   (input valid, z_real, z_imag, output ready);
endinterface

[rtl/core/jetc_out_if.sv]
// Output stream: one iteration count per transfer.
// No package dependency; width set by COUNT_BITS.
interface jetc_out_if #(
  parameter int COUNT_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] iteration_count;

  modport source (output valid, iteration_count, input ready);
  modport sink   (input valid, iteration_count, output ready);
endinterface

[rtl/core/jetc_ctrl.sv]
// Sequencer for the escape-time loop: handshakes and datapath commands.
// Depends on jetc_pkg.
module jetc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  jetc_pkg::stat_t stat,
  output jetc_pkg::cmd_t  cmd
);
  import jetc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_EVAL,
    S_FINISH
  } state_t;

  state_t state;

  always_comb begin
    cmd      = '0;
    in_ready = (state == S_IDLE);
    case (state)
      S_IDLE:   cmd.load    = in_valid;
      S_MUL:    cmd.mult    = 1'b1;
      S_EVAL:   cmd.step    = stat.keep_going;
      S_FINISH: cmd.publish = !out_valid || out_ready;
      default:  cmd         = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL:  state <= S_EVAL;
        S_EVAL: state <= stat.keep_going ? S_MUL : S_FINISH;
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // never overwrite a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("result overwritten while pending");

  // a new result only comes out of the finish step
  a_rise_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result raised outside finish");

  // an accepted point always goes straight to the multiply step
  a_load_to_mul: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MUL))
    else $error("accepted point did not start");
`endif

endmodule

[rtl/core/jetc_dp.sv]
// Datapath: config registers, z registers, products, update and escape test.
// Depends on jetc_pkg.
module jetc_dp #(
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [jetc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jetc_pkg::CFG_W-1:0]          cfg_data,
  input  logic signed [jetc_pkg::DATA_W-1:0]  z_real,
  input  logic signed [jetc_pkg::DATA_W-1:0]  z_imag,
  input  jetc_pkg::cmd_t                      cmd,
  output jetc_pkg::stat_t                     stat,
  output logic [COUNT_BITS-1:0]               iteration_count
);
  import jetc_pkg::*;

  localparam int CMP_W = (DATA_W + FRAC_BITS > PROD_W) ? DATA_W + FRAC_BITS : PROD_W;
  localparam int CW    = (COUNT_BITS > ITER_W) ? COUNT_BITS : ITER_W;

  logic signed [DATA_W-1:0] c_real_q, c_imag_q;
  logic [ITER_W-1:0]        max_iter_q;
  logic [DATA_W-1:0]        esc_lim_q;

  logic signed [DATA_W-1:0] x_q, y_q;
  logic [ITER_W-1:0]        count_q;
  logic                     sat_q;
  logic signed [PROD_W-1:0] xx_q, yy_q, xy_q;
  logic [COUNT_BITS-1:0]    result_q;

  logic signed [PROD_W-1:0] diff, re_sh, im_sh;
  logic signed [PROD_W:0]   re_sum, im_sum;
  logic                     re_ovf, im_ovf, in_radius;
  logic signed [DATA_W-1:0] x_next, y_next;
  logic [PROD_W-1:0]        mag;
  logic [CMP_W-1:0]         mag_ext, lim_ext;
  logic [CW-1:0]            count_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_real_q   <= C_RESET;
      c_imag_q   <= C_RESET;
      max_iter_q <= MAX_IT_RESET;
      esc_lim_q  <= ESC_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_C_REAL:    c_real_q   <= cfg_data[DATA_W-1:0];
        CFG_C_IMAG:    c_imag_q   <= cfg_data[DATA_W-1:0];
        CFG_MAX_ITER:  max_iter_q <= cfg_data[ITER_W-1:0];
        CFG_ESC_LIMIT: esc_lim_q  <= cfg_data[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // products formed exactly; floor scaling via arithmetic shift
  always_comb begin
    diff   = xx_q - yy_q;
    re_sh  = diff >>> FRAC_BITS;
    im_sh  = xy_q >>> (FRAC_BITS - 1);
    re_sum = (PROD_W+1)'(re_sh) + (PROD_W+1)'(c_real_q);
    im_sum = (PROD_W+1)'(im_sh) + (PROD_W+1)'(c_imag_q);
    re_ovf = !((&re_sum[PROD_W:DATA_W-1]) || !(|re_sum[PROD_W:DATA_W-1]));
    im_ovf = !((&im_sum[PROD_W:DATA_W-1]) || !(|im_sum[PROD_W:DATA_W-1]));
    x_next = re_ovf ? (re_sum[PROD_W] ? SMIN : SMAX) : re_sum[DATA_W-1:0];
    y_next = im_ovf ? (im_sum[PROD_W] ? SMIN : SMAX) : im_sum[DATA_W-1:0];
    // both squares nonnegative, sum fits unsigned
    mag       = $unsigned(xx_q) + $unsigned(yy_q);
    mag_ext   = CMP_W'(mag);
    lim_ext   = CMP_W'(esc_lim_q) << FRAC_BITS;
    in_radius = (mag_ext <= lim_ext);
    stat.keep_going = (count_q < max_iter_q) && !sat_q && in_radius;
  end

  assign count_wide      = CW'(count_q);
  assign iteration_count = result_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_q     <= z_real;
      y_q     <= z_imag;
      count_q <= '0;
      sat_q   <= 1'b0;
    end else if (cmd.step) begin
      x_q     <= x_next;
      y_q     <= y_next;
      count_q <= count_q + 1'b1;
      sat_q   <= re_ovf || im_ovf;
    end
    if (cmd.mult) begin
      xx_q <= x_q * x_q;
      yy_q <= y_q * y_q;
      xy_q <= x_q * y_q;
    end
    if (cmd.publish) begin
      result_q <= count_wide[COUNT_BITS-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  // each committed step advances the count by exactly one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> count_q == $past(count_q) + 1'b1)
    else $error("count did not advance on step");

  // a step never takes the count past the limit
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> count_q < max_iter_q)
    else $error("step beyond iteration limit");

  // a fresh point starts clean
  a_load_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (count_q == '0) && !sat_q)
    else $error("point not initialized on load");
`endif

endmodule

[rtl/core/julia_escape_time_counter.sv]
// Julia set escape-time counter, top level: sequencer plus datapath.
// Depends on jetc_pkg, jetc_in_if, jetc_out_if, jetc_ctrl, jetc_dp.
//
// Takes one starting point z (signed Q3.28 real/imag) per input transfer
// and returns one iteration count per output transfer. While the count is
// below max_iterations and |z|^2 <= escape_limit_sq, it applies
// z = z*z + c. Squares are exact 64-bit products, scaled back with floor
// rounding; each new component saturates to 32 bits, and a saturated step
// is counted and ends the point. Points are handled one at a time. Each
// iteration passes through the three 32x32 multipliers into product
// registers, then through the update, saturation and escape compare. The
// finished count sits in an output register, so a new point is accepted
// while the previous count still waits for its transfer. Configuration
// registers (index 0 c_real, 1 c_imag, 2 max_iterations, 3 escape_limit_sq)
// are written through cfg_we/cfg_index/cfg_data; the user must write them
// only while the block is idle, and the block itself does not enforce this;
// reset values are c = 0, limit 1000, escape_limit_sq 4.0.
module julia_escape_time_counter #(
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  jetc_in_if.sink                         in_ch,
  jetc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [jetc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jetc_pkg::CFG_W-1:0]      cfg_data
);
  import jetc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // control: handshakes and step sequencing
  jetc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic, config registers and result register
  jetc_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .z_real          (in_ch.z_real),
    .z_imag          (in_ch.z_imag),
    .cmd             (cmd),
    .stat            (stat),
    .iteration_count (out_ch.iteration_count)
  );

endmodule
